FILE: src/spatial_vote_table_assert.svh
// assertion macros for the spatial vote table
// expects clk and arst_n in the scope of each use
`ifndef SPATIAL_VOTE_TABLE_ASSERT_SVH
`define SPATIAL_VOTE_TABLE_ASSERT_SVH

// same-cycle implication
`define SVT_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define SVT_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

FILE: src/svt_pkg.sv
// shared types, constants and helpers for the spatial vote table
// no dependencies
package svt_pkg;

	localparam int TABLE_DEPTH = 64;
	localparam int IDX_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
	localparam int CNT_W = $clog2(TABLE_DEPTH + 1);
	localparam int COORD_W = 16;
	localparam int TOL_W = 15;
	localparam int VOTE_W = 8;
	localparam int SLOT_W = 6;
	localparam int TOTAL_W = 7;
	localparam int CFG_IDX_W = 2;
	localparam int CFG_DATA_W = 15;

	localparam logic [VOTE_W-1:0] VOTE_MAX = '1;
	localparam logic [TOTAL_W-1:0] TOTAL_MAX = '1;
	localparam logic [TOL_W-1:0] TOL_RESET = TOL_W'(100);
	localparam logic [VOTE_W-1:0] CONF_RESET = VOTE_W'(3);
	localparam logic [CNT_W-1:0] USED_FULL = CNT_W'(TABLE_DEPTH);

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_TOLERANCE = 2'd0,
		REG_CONFIRM = 2'd1
	} cfg_reg_t;

	// item travelling along the chain
	typedef struct packed {
		logic signed [COORD_W-1:0] x;
		logic signed [COORD_W-1:0] y;
		logic signed [COORD_W-1:0] z;
		logic done;
		logic matched;
		logic [IDX_W-1:0] slot;
		logic [VOTE_W-1:0] votes;
		logic fresh;
	} link_t;

	// shared control seen by every cell
	typedef struct packed {
		logic adv;
		logic [TOL_W-1:0] tol;
		logic [VOTE_W-1:0] confv;
		logic [CNT_W-1:0] used;
	} cell_ctl_t;

	function automatic logic axis_close(logic signed [COORD_W-1:0] a,
			logic signed [COORD_W-1:0] b, logic [TOL_W-1:0] tol);
		logic signed [COORD_W:0] d;
		logic [COORD_W:0] m;
		d = {a[COORD_W-1], a} - {b[COORD_W-1], b};
		m = d[COORD_W] ? (COORD_W+1)'(-d) : d;
		return m < {{(COORD_W + 1 - TOL_W){1'b0}}, tol};
	endfunction

endpackage

FILE: src/svt_cell.sv
// one table cell: holds one entry, votes or inserts as the item passes
// depends on svt_pkg
module svt_cell import svt_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  cell_ctl_t ctl,
	input  logic [IDX_W-1:0] cell_idx,
	input  logic in_vld,
	input  link_t in_link,
	output logic out_vld,
	output link_t out_link
);

	logic signed [COORD_W-1:0] ex_q, ey_q, ez_q;
	logic [VOTE_W-1:0] ev_q;
	logic vld_q;
	link_t link_q;
	link_t link_n;
	logic in_use, hit, ins, inc;
	logic [VOTE_W-1:0] nv;

	assign in_use = CNT_W'(cell_idx) < ctl.used;
	assign hit = in_vld && !in_link.done && in_use && axis_close(ex_q, in_link.x, ctl.tol)
		&& axis_close(ey_q, in_link.y, ctl.tol) && axis_close(ez_q, in_link.z, ctl.tol);
	assign ins = in_vld && !in_link.done && (CNT_W'(cell_idx) == ctl.used);
	assign inc = ev_q != VOTE_MAX;
	assign nv = inc ? ev_q + VOTE_W'(1) : ev_q;

	always_comb begin
		link_n = in_link;
		if (hit) begin
			link_n.done = 1'b1;
			link_n.matched = 1'b1;
			link_n.slot = cell_idx;
			link_n.votes = nv;
			link_n.fresh = inc && (nv == ctl.confv);
		end else if (ins) begin
			link_n.done = 1'b1;
			link_n.slot = cell_idx;
			link_n.votes = VOTE_W'(1);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= 1'b0;
		end else if (ctl.adv) begin
			vld_q <= in_vld;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.adv) begin
			link_q <= link_n;
			if (hit) begin
				ev_q <= nv;
			end else if (ins) begin
				ex_q <= in_link.x;
				ey_q <= in_link.y;
				ez_q <= in_link.z;
				ev_q <= VOTE_W'(1);
			end
		end
	end

	assign out_vld = vld_q;
	assign out_link = link_q;

endmodule

FILE: src/spatial_vote_table.sv
// top level of the spatial vote table: config registers, cell chain, result register
// depends on svt_pkg, svt_cell and spatial_vote_table_assert.svh
//
// usage:
// input channel in_valid/in_stall carries one observation (obs_x, obs_y, obs_z).
// output channel out_valid/out_stall carries one result item per observation.
// config channel cfg_valid/cfg_ready (cfg_ready always high) writes
// match_tolerance at index 0 and confirm_votes at index 1; others are ignored.
// the item walks the chain of TABLE_DEPTH cells, one cell per cycle; the
// first close entry takes the vote, else the first free cell stores it, else
// the item is dropped and flagged with table_full. the result is registered
// after the last cell; only one item is in the chain at a time, and a new
// item is taken while the previous result still waits on the output.
// in_stall is high from accept until the result reaches the output register.
// when the receiver stalls, the result holds and an item at the end of the
// chain freezes until the output register frees up.
// reset empties the table, clears the confirmed count, loads tolerance 100 and
// confirm count 3; no clearing pass is needed.
module spatial_vote_table import svt_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic cfg_valid,
	output logic cfg_ready,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	input  logic in_valid,
	output logic in_stall,
	input  logic signed [COORD_W-1:0] obs_x,
	input  logic signed [COORD_W-1:0] obs_y,
	input  logic signed [COORD_W-1:0] obs_z,
	output logic out_valid,
	input  logic out_stall,
	output logic matched,
	output logic [SLOT_W-1:0] slot_index,
	output logic [VOTE_W-1:0] votes_now,
	output logic newly_confirmed,
	output logic [TOTAL_W-1:0] confirmed_total,
	output logic table_full
);

	`include "spatial_vote_table_assert.svh"

	logic [TOL_W-1:0] tol_q;
	logic [VOTE_W-1:0] confv_q;
	logic [CNT_W-1:0] used_q;
	logic [TOTAL_W-1:0] total_q;
	logic busy_q;
	logic out_vld_q;
	logic matched_q, fresh_q, full_q;
	logic [SLOT_W-1:0] slot_q;
	logic [VOTE_W-1:0] votes_q;

	logic vld_w [0:TABLE_DEPTH];
	link_t link_w [0:TABLE_DEPTH];
	cell_ctl_t ctl;
	logic accept, tail, load, adv, inserted;
	logic [TOTAL_W-1:0] total_n;
	link_t lk;

	assign cfg_ready = 1'b1;
	assign in_stall = busy_q;
	assign accept = in_valid && !busy_q;

	assign tail = vld_w[TABLE_DEPTH];
	assign lk = link_w[TABLE_DEPTH];
	assign adv = !(tail && out_vld_q && out_stall);
	assign load = tail && adv;
	assign inserted = lk.done && !lk.matched;
	assign total_n = (lk.fresh && (total_q != TOTAL_MAX)) ? total_q + TOTAL_W'(1) : total_q;

	assign ctl = '{adv: adv, tol: tol_q, confv: confv_q, used: used_q};

	assign vld_w[0] = accept;
	assign link_w[0] = '{x: obs_x, y: obs_y, z: obs_z, done: 1'b0, matched: 1'b0,
		slot: '0, votes: '0, fresh: 1'b0};

	for (genvar k = 0; k < TABLE_DEPTH; k++) begin : g_cell
		svt_cell u_cell (
			.clk(clk),
			.arst_n(arst_n),
			.ctl(ctl),
			.cell_idx(IDX_W'(k)),
			.in_vld(vld_w[k]),
			.in_link(link_w[k]),
			.out_vld(vld_w[k+1]),
			.out_link(link_w[k+1])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tol_q <= TOL_RESET;
			confv_q <= CONF_RESET;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				REG_TOLERANCE: tol_q <= cfg_data[TOL_W-1:0];
				REG_CONFIRM: confv_q <= cfg_data[VOTE_W-1:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			out_vld_q <= 1'b0;
			used_q <= '0;
			total_q <= '0;
		end else begin
			if (accept) begin
				busy_q <= 1'b1;
			end else if (load) begin
				busy_q <= 1'b0;
			end
			if (load) begin
				out_vld_q <= 1'b1;
				total_q <= total_n;
				if (inserted) begin
					used_q <= used_q + CNT_W'(1);
				end
			end else if (!out_stall) begin
				out_vld_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			matched_q <= lk.matched;
			slot_q <= SLOT_W'(lk.slot);
			votes_q <= lk.votes;
			fresh_q <= lk.fresh;
			full_q <= !lk.done && (used_q == USED_FULL);
		end
	end

	assign out_valid = out_vld_q;
	assign matched = matched_q;
	assign slot_index = slot_q;
	assign votes_now = votes_q;
	assign newly_confirmed = fresh_q;
	assign confirmed_total = total_q;
	assign table_full = full_q;

	`SVT_ASSERT_NOW(a_tail_busy, tail, busy_q, "item in chain while not busy")
	`SVT_ASSERT_NOW(a_used_bound, 1'b1, used_q <= USED_FULL, "entry count past depth")
	`SVT_ASSERT_NOW(a_insert_room, load && inserted, used_q != USED_FULL, "insert into full table")
	`SVT_ASSERT_NEXT(a_accept_busy, accept, busy_q, "accept did not set busy")

endmodule

FILE: tb/testbench.sv
// testbench for spatial_vote_table: directed and random observations scored
// against an in-house model of the vote table, with random idling on both channels
// depends on svt_pkg and the spatial_vote_table rtl
module testbench;
	import svt_pkg::*;

	localparam int WATCHDOG_LIMIT = 3000;
	localparam int LONG_HOLD = 400;
	localparam int SETTLE_CYCLES = 200;
	localparam logic [CFG_IDX_W-1:0] REG_SPARE_A = 2'd2;
	localparam logic [CFG_IDX_W-1:0] REG_SPARE_B = 2'd3;

	typedef logic signed [COORD_W-1:0] coord_t;

	typedef struct packed {
		logic matched;
		logic [SLOT_W-1:0] slot;
		logic [VOTE_W-1:0] votes;
		logic fresh;
		logic [TOTAL_W-1:0] total;
		logic full;
	} vote_result_t;

	typedef struct {
		int tol;
		int conf;
		int src;
		int dst;
		int items;
	} phase_t;

	class vote_scoreboard;
		coord_t xpos[TABLE_DEPTH];
		coord_t ypos[TABLE_DEPTH];
		coord_t zpos[TABLE_DEPTH];
		logic [VOTE_W-1:0] votes[TABLE_DEPTH];
		int used;
		logic [TOTAL_W-1:0] confirmed;
		logic [TOL_W-1:0] tol;
		logic [VOTE_W-1:0] confv;
		vote_result_t expected_q[$];
		int errors, n_checked, n_match, n_new, n_drop, n_fresh, n_sat;

		function new();
			used = 0;
			confirmed = '0;
			tol = TOL_RESET;
			confv = CONF_RESET;
			errors = 0;
			n_checked = 0;
			n_match = 0;
			n_new = 0;
			n_drop = 0;
			n_fresh = 0;
			n_sat = 0;
		endfunction

		function bit axis_near(coord_t a, coord_t b);
			int d;
			d = int'(a) - int'(b);
			if (d < 0)
				d = -d;
			return d < int'(tol);
		endfunction

		function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
			if (idx == REG_TOLERANCE)
				tol = data[TOL_W-1:0];
			else if (idx == REG_CONFIRM)
				confv = data[VOTE_W-1:0];
		endfunction

		// first close entry in insertion order takes the vote, else append, else drop
		function void note_input(coord_t x, coord_t y, coord_t z);
			vote_result_t r;
			int hit;
			r = '0;
			hit = -1;
			for (int i = 0; i < used && hit < 0; i++)
				if (axis_near(xpos[i], x) && axis_near(ypos[i], y) && axis_near(zpos[i], z))
					hit = i;
			if (hit >= 0) begin
				r.matched = 1'b1;
				r.slot = SLOT_W'(hit);
				if (votes[hit] == VOTE_MAX) begin
					n_sat++;
				end else begin
					votes[hit]++;
					if (votes[hit] == confv) begin
						r.fresh = 1'b1;
						n_fresh++;
						if (confirmed != TOTAL_MAX)
							confirmed++;
					end
				end
				r.votes = votes[hit];
				n_match++;
			end else if (used < TABLE_DEPTH) begin
				r.slot = SLOT_W'(used);
				xpos[used] = x;
				ypos[used] = y;
				zpos[used] = z;
				votes[used] = VOTE_W'(1);
				r.votes = VOTE_W'(1);
				used++;
				n_new++;
			end else begin
				r.full = 1'b1;
				n_drop++;
			end
			r.total = confirmed;
			expected_q = {expected_q, r};
		endfunction

		function void compare_field(string name, logic [15:0] want, logic [15:0] got);
			if (got !== want) begin
				$display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
				errors++;
			end
		endfunction

		function void check_result(vote_result_t got);
			vote_result_t want;
			if (expected_q.size() == 0) begin
				$display("%0t: unexpected result, expected none, got %h", $time, got);
				errors++;
			end else begin
				want = expected_q.pop_front();
				n_checked++;
				compare_field("matched", 16'(want.matched), 16'(got.matched));
				compare_field("slot_index", 16'(want.slot), 16'(got.slot));
				compare_field("votes_now", 16'(want.votes), 16'(got.votes));
				compare_field("newly_confirmed", 16'(want.fresh), 16'(got.fresh));
				compare_field("confirmed_total", 16'(want.total), 16'(got.total));
				compare_field("table_full", 16'(want.full), 16'(got.full));
			end
		endfunction

		function int pending();
			return expected_q.size();
		endfunction
	endclass

	logic clk;
	logic arst_n;
	logic cfg_valid;
	logic cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;
	logic in_valid;
	logic in_stall;
	coord_t obs_x;
	coord_t obs_y;
	coord_t obs_z;
	logic out_valid;
	logic out_stall;
	logic matched;
	logic [SLOT_W-1:0] slot_index;
	logic [VOTE_W-1:0] votes_now;
	logic newly_confirmed;
	logic [TOTAL_W-1:0] confirmed_total;
	logic table_full;

	vote_scoreboard sb = new();
	int src_idle = 18;
	int dst_idle = 73;
	bit hold_pending = 1'b0;
	int quiet_cycles = 0;

	spatial_vote_table dut (.*);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if (out_valid && !out_stall)
				sb.check_result(vote_result_t'({matched, slot_index, votes_now,
					newly_confirmed, confirmed_total, table_full}));
			if (in_valid && !in_stall)
				sb.note_input(obs_x, obs_y, obs_z);
			if (cfg_valid && cfg_ready)
				sb.write_reg(cfg_index, cfg_data);
		end
		if ((out_valid && !out_stall) || (in_valid && !in_stall) || (cfg_valid && cfg_ready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
	end

	initial begin
		do @(posedge clk); while (quiet_cycles < WATCHDOG_LIMIT);
		$display("[FAIL] regression broken");
		$finish;
	end

	// receiver: random stall, or a long hold-off when asked
	initial begin
		int hold_left;
		hold_left = 0;
		out_stall <= 1'b0;
		forever begin
			@(posedge clk);
			if (hold_pending) begin
				hold_pending = 1'b0;
				hold_left = LONG_HOLD;
			end
			if (hold_left > 0) begin
				out_stall <= 1'b1;
				hold_left--;
			end else begin
				out_stall <= ($urandom_range(99) < dst_idle);
			end
		end
	end

	task automatic send_obs(int x, int y, int z);
		while ($urandom_range(99) < src_idle) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		obs_x <= coord_t'(x);
		obs_y <= coord_t'(y);
		obs_z <= coord_t'(z);
		do @(posedge clk); while (in_stall);
	endtask

	task automatic drain();
		in_valid <= 1'b0;
		do @(posedge clk); while (sb.pending() != 0);
	endtask

	task automatic write_cfg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		@(posedge clk);
	endtask

	function automatic coord_t extreme_coord();
		case ($urandom_range(3))
			0: return coord_t'(-32768);
			1: return coord_t'(32767);
			2: return coord_t'(0);
			default: return coord_t'(-1);
		endcase
	endfunction

	// mostly inside the tolerance, sometimes right on or just past it
	function automatic coord_t near_axis(coord_t base, int span);
		int m;
		int pick;
		pick = $urandom_range(9);
		if (pick < 7)
			m = (span > 0) ? $urandom_range(span - 1) : 0;
		else if (pick == 7)
			m = span;
		else if (pick == 8)
			m = (span > 0) ? span - 1 : 0;
		else
			m = span + 1;
		return coord_t'($urandom_range(1) ? int'(base) + m : int'(base) - m);
	endfunction

	task automatic send_random();
		coord_t x, y, z;
		int k;
		int pick;
		pick = $urandom_range(99);
		if (sb.used == 0 || pick < 15) begin
			x = coord_t'($urandom);
			y = coord_t'($urandom);
			z = coord_t'($urandom);
		end else if (pick < 20) begin
			x = extreme_coord();
			y = extreme_coord();
			z = extreme_coord();
		end else begin
			k = $urandom_range(sb.used - 1);
			x = near_axis(sb.xpos[k], int'(sb.tol));
			y = near_axis(sb.ypos[k], int'(sb.tol));
			z = near_axis(sb.zpos[k], int'(sb.tol));
		end
		send_obs(int'(x), int'(y), int'(z));
	endtask

	initial begin
		phase_t plan[8];
		arst_n <= 1'b0;
		cfg_valid <= 1'b0;
		cfg_index <= REG_TOLERANCE;
		cfg_data <= '0;
		in_valid <= 1'b0;
		obs_x <= '0;
		obs_y <= '0;
		obs_z <= '0;
		plan[0] = '{100, 3, 18, 73, 235};
		plan[1] = '{0, 1, 18, 73, 200};
		plan[2] = '{32767, 255, 18, 73, 260};
		plan[3] = '{500, 10, 73, 18, 235};
		plan[4] = '{$urandom_range(5000, 1), $urandom_range(60, 2), 73, 18, 235};
		plan[5] = '{32767, 0, 73, 18, 235};
		plan[6] = '{1, 255, 0, 0, 235};
		plan[7] = '{300, 40, 0, 0, 235};
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset values: tolerance 100, confirm at 3
		send_obs(-32768, -32768, -32768);
		send_obs(32767, 32767, 32767);
		send_obs(-32768, -32768, -32768);
		send_obs(-32669, -32768, -32768);
		send_obs(-32668, -32768, -32768);
		send_obs(32767, 32668, 32767);
		send_obs(0, 0, 0);
		send_obs(-1, 1, -99);
		send_obs(99, -99, 0);
		send_obs(0, 0, 0);
		send_obs(0, 0, 100);
		drain();

		// tolerance zero, confirm at 1, spare indexes ignored
		write_cfg(REG_TOLERANCE, '0);
		write_cfg(REG_CONFIRM, CFG_DATA_W'({7'($urandom), 8'd1}));
		write_cfg(REG_SPARE_A, CFG_DATA_W'($urandom));
		write_cfg(REG_SPARE_B, CFG_DATA_W'($urandom));
		send_obs(0, 0, 0);
		send_obs(0, 0, 0);
		drain();

		// widest tolerance
		write_cfg(REG_TOLERANCE, CFG_DATA_W'(32767));
		write_cfg(REG_CONFIRM, CFG_DATA_W'(2));
		send_obs(0, 0, 0);
		send_obs(-32768, -32768, -32768);
		send_obs(32767, 32767, 32767);

		foreach (plan[p]) begin
			drain();
			write_cfg(REG_TOLERANCE, CFG_DATA_W'(plan[p].tol));
			write_cfg(REG_CONFIRM, CFG_DATA_W'({7'($urandom), 8'(plan[p].conf)}));
			if (p == 4)
				write_cfg(REG_SPARE_B, CFG_DATA_W'($urandom));
			src_idle = plan[p].src;
			dst_idle = plan[p].dst;
			if (p == 6)
				hold_pending = 1'b1;
			for (int n = 0; n < plan[p].items; n++) begin
				if (p == 7 && n == plan[p].items / 2)
					drain();
				send_random();
			end
		end
		drain();
		repeat (SETTLE_CYCLES) @(posedge clk);

		$display("checked %0d results: %0d votes, %0d new entries, %0d dropped",
			sb.n_checked, sb.n_match, sb.n_new, sb.n_drop);
		$display("%0d confirmations, %0d hits on saturated entries, %0d entries in use",
			sb.n_fresh, sb.n_sat, sb.used);
		if (sb.errors == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end
endmodule

FILE: filelist.f
+incdir+src
src/svt_pkg.sv
src/svt_cell.sv
src/spatial_vote_table.sv
tb/testbench.sv
